// ===== design/cnv_pkg.sv =====
// Package for the card number validator: types, codes and digit helpers.
`timescale 1ns / 1ps

package cnv_pkg;

	localparam int unsigned CHAR_W   = 8;
	localparam int unsigned LEN_W    = 5;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned BRAND_W  = 3;
	localparam int unsigned DIGIT_W  = 4;
	localparam int unsigned LEAD_W   = 2 * DIGIT_W;
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned ADDR_W   = 3;

	localparam logic [LEN_W-1:0] COUNT_MAX       = 5'd31;
	localparam logic [LEN_W-1:0] MIN_LEN_RESET   = 5'd13;
	localparam logic [LEN_W-1:0] MAX_LEN_RESET   = 5'd19;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
	localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;

	localparam logic [DIGIT_W-1:0] DIG_THREE = 4'd3;
	localparam logic [DIGIT_W-1:0] DIG_FOUR  = 4'd4;
	localparam logic [DIGIT_W-1:0] DIG_FIVE  = 4'd5;
	localparam logic [DIGIT_W-1:0] DIG_SIX   = 4'd6;
	localparam logic [DIGIT_W-1:0] DIG_SEVEN = 4'd7;
	localparam logic [DIGIT_W-1:0] DIG_NINE  = 4'd9;
	localparam logic [DIGIT_W:0]   DIG_TEN   = 5'd10;

	typedef enum logic [0:0] {
		REG_MIN_LENGTH = 1'b0,
		REG_MAX_LENGTH = 1'b1
	} reg_index_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_VALID    = 2'd0,
		ST_NONDIGIT = 2'd1,
		ST_LENGTH   = 2'd2,
		ST_LUHN     = 2'd3
	} status_t;

	typedef enum logic [BRAND_W-1:0] {
		BR_OTHER      = 3'd0,
		BR_VISA       = 3'd1,
		BR_MASTERCARD = 3'd2,
		BR_MAESTRO    = 3'd3,
		BR_JCB        = 3'd4,
		BR_AMEX       = 3'd5
	} brand_t;

	typedef struct packed {
		logic [LEN_W-1:0] min_length;
		logic [LEN_W-1:0] max_length;
	} cnv_cfg_t;

	function automatic logic is_blank(input logic [CHAR_W-1:0] c);
		return ((c >= CHAR_TAB) && (c <= CHAR_CR)) || (c == CHAR_SPACE);
	endfunction

	function automatic logic is_digit(input logic [CHAR_W-1:0] c);
		return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
	endfunction

	function automatic logic [DIGIT_W-1:0] doubled_digit(input logic [DIGIT_W-1:0] d);
		logic [DIGIT_W:0] t;
		t = {d, 1'b0};
		if (t > {1'b0, DIG_NINE}) begin
			t = t - {1'b0, DIG_NINE};
		end
		return t[DIGIT_W-1:0];
	endfunction

	function automatic logic [DIGIT_W-1:0] add_mod10(input logic [DIGIT_W-1:0] a,
			input logic [DIGIT_W-1:0] b);
		logic [DIGIT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= DIG_TEN) begin
			s = s - DIG_TEN;
		end
		return s[DIGIT_W-1:0];
	endfunction

endpackage

// ===== design/cnv_ifs.sv =====
// Stream interfaces for character words in and result words out.
`timescale 1ns / 1ps

interface cnv_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       is_last;

	modport source (output valid, output char_byte, output is_last, input ready);
	modport sink (input valid, input char_byte, input is_last, output ready);
endinterface

interface cnv_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [2:0] brand;
	logic [4:0] digit_count;

	modport source (output valid, output status, output brand, output digit_count,
		input ready);
	modport sink (input valid, input status, input brand, input digit_count,
		output ready);
endinterface

// ===== design/cnv_apb_regs.sv =====
// APB register block holding the length bounds.
`timescale 1ns / 1ps

module cnv_apb_regs
	import cnv_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cnv_cfg_t          cfg
);

	logic [LEN_W-1:0] min_length_q;
	logic [LEN_W-1:0] max_length_q;
	reg_index_t       idx;
	logic             wr_en;

	assign pready = 1'b1;
	assign idx    = reg_index_t'(paddr[2]);
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q <= MIN_LEN_RESET;
			max_length_q <= MAX_LEN_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_MIN_LENGTH: min_length_q <= pwdata[LEN_W-1:0];
				REG_MAX_LENGTH: max_length_q <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MIN_LENGTH: prdata = {{(DATA_W-LEN_W){1'b0}}, min_length_q};
			REG_MAX_LENGTH: prdata = {{(DATA_W-LEN_W){1'b0}}, max_length_q};
			default:        prdata = '0;
		endcase
	end

	assign cfg.min_length = min_length_q;
	assign cfg.max_length = max_length_q;

endmodule

// ===== design/cnv_luhn_core.sv =====
// Input register, running Luhn state and result register.
`timescale 1ns / 1ps

module cnv_luhn_core
	import cnv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cnv_cfg_t    cfg,
	cnv_char_if.sink    char_in,
	cnv_res_if.source   res_out
);

	logic                valid_s1;
	logic [CHAR_W-1:0]   char_s1;
	logic                last_s1;

	logic [LEN_W-1:0]    count_q;
	logic                bad_char_q;
	logic [DIGIT_W-1:0]  sum_even_q;
	logic [DIGIT_W-1:0]  sum_odd_q;
	logic [LEAD_W-1:0]   lead_q;

	logic                out_valid_q;
	status_t             status_q;
	brand_t              brand_q;
	logic [LEN_W-1:0]    count_out_q;

	logic                advance;
	logic                take_in;
	logic                dig;
	logic [DIGIT_W-1:0]  d;
	logic [LEN_W-1:0]    count_n;
	logic                bad_n;
	logic [DIGIT_W-1:0]  sum_even_n;
	logic [DIGIT_W-1:0]  sum_odd_n;
	logic [LEAD_W-1:0]   lead_n;
	logic [DIGIT_W-1:0]  first_d;
	logic [DIGIT_W-1:0]  second_d;
	status_t             status_n;
	brand_t              brand_n;

	assign advance = valid_s1 && (!last_s1 || !out_valid_q || res_out.ready);
	assign char_in.ready = !valid_s1 || advance;
	assign take_in = char_in.valid && char_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_in.ready) begin
			valid_s1 <= char_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			char_s1 <= char_in.char_byte;
			last_s1 <= char_in.is_last;
		end
	end

	always_comb begin
		dig        = is_digit(char_s1);
		d          = char_s1[DIGIT_W-1:0];
		count_n    = count_q;
		bad_n      = bad_char_q;
		sum_even_n = sum_even_q;
		sum_odd_n  = sum_odd_q;
		lead_n     = lead_q;
		if (dig) begin
			sum_odd_n  = add_mod10(sum_even_q, d);
			sum_even_n = add_mod10(sum_odd_q, doubled_digit(d));
			if (count_q == '0) begin
				lead_n = {d, {DIGIT_W{1'b0}}};
			end else if (count_q == LEN_W'(1)) begin
				lead_n = {lead_q[LEAD_W-1:DIGIT_W], d};
			end
			if (count_q != COUNT_MAX) begin
				count_n = count_q + LEN_W'(1);
			end
		end else if (!is_blank(char_s1)) begin
			bad_n = 1'b1;
		end
	end

	always_comb begin
		first_d  = lead_n[LEAD_W-1:DIGIT_W];
		second_d = lead_n[DIGIT_W-1:0];
		if (bad_n) begin
			status_n = ST_NONDIGIT;
		end else if ((count_n < cfg.min_length) || (count_n > cfg.max_length)) begin
			status_n = ST_LENGTH;
		end else if (sum_odd_n != '0) begin
			status_n = ST_LUHN;
		end else begin
			status_n = ST_VALID;
		end
		if (count_n == '0) begin
			brand_n = BR_OTHER;
		end else if ((count_n >= LEN_W'(2)) && (first_d == DIG_THREE)
				&& ((second_d == DIG_FOUR) || (second_d == DIG_SEVEN))) begin
			brand_n = BR_AMEX;
		end else if (first_d == DIG_THREE) begin
			brand_n = BR_JCB;
		end else if (first_d == DIG_FOUR) begin
			brand_n = BR_VISA;
		end else if (first_d == DIG_FIVE) begin
			brand_n = BR_MASTERCARD;
		end else if (first_d == DIG_SIX) begin
			brand_n = BR_MAESTRO;
		end else begin
			brand_n = BR_OTHER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			bad_char_q <= 1'b0;
			sum_even_q <= '0;
			sum_odd_q  <= '0;
			lead_q     <= '0;
		end else if (advance) begin
			if (last_s1) begin
				count_q    <= '0;
				bad_char_q <= 1'b0;
				sum_even_q <= '0;
				sum_odd_q  <= '0;
				lead_q     <= '0;
			end else begin
				count_q    <= count_n;
				bad_char_q <= bad_n;
				sum_even_q <= sum_even_n;
				sum_odd_q  <= sum_odd_n;
				lead_q     <= lead_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (res_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			status_q    <= status_n;
			brand_q     <= brand_n;
			count_out_q <= count_n;
		end
	end

	assign res_out.valid       = out_valid_q;
	assign res_out.status      = status_q;
	assign res_out.brand       = brand_q;
	assign res_out.digit_count = count_out_q;

endmodule

// ===== design/card_number_validator_top.sv =====
// Top level of the card number validator.
`timescale 1ns / 1ps

// Card number validator. Characters of a card number arrive one word per
// cycle on char_in, the final one flagged by is_last; tab, newline, vertical
// tab, form feed, carriage return and space are skipped. A new word is
// accepted every cycle into the input register ahead of the Luhn state
// update; the result word is registered in the output register on res_out,
// and the next number may start at once. A last character is held back only
// while the previous result still waits in the output register. The user
// writes the length bounds min_length (address 0, reset 13) and max_length
// (address 4, reset 19) over the APB port between numbers; the block does
// not enforce it. Status is non-digit, then bad length, then Luhn failure,
// then valid; the brand comes from the first two digits.
module card_number_validator_top
	import cnv_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	cnv_char_if.sink          char_in,
	cnv_res_if.source         res_out
);

	cnv_cfg_t cfg;

	cnv_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cnv_luhn_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.char_in (char_in),
		.res_out (res_out)
	);

endmodule

// ===== tb/tb_card_number_validator_top.sv =====
// Testbench for the card number validator: random and directed character streams checked against a Luhn predictor.
`timescale 1ns / 1ps

module tb_card_number_validator_top;
	import cnv_pkg::*;

	typedef struct {
		logic [CHAR_W-1:0] ch;
		logic              is_end;
	} char_word_t;

	typedef struct {
		status_t          status;
		brand_t           brand;
		logic [LEN_W-1:0] count;
	} verdict_t;

	localparam int HOLD_LEN    = 300;
	localparam int STALL_LIMIT = 4000;
	localparam int SETTLE      = 8;
	localparam int PRINT_CAP   = 20;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	cnv_char_if char_if ();
	cnv_res_if  res_if ();

	card_number_validator_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.char_in (char_if),
		.res_out (res_if)
	);

	char_word_t pending_words[$];
	verdict_t   expected_verdicts[$];
	char_word_t next_word;
	verdict_t   want_verdict;

	logic [LEN_W-1:0]   len_min;
	logic [LEN_W-1:0]   len_max;
	logic [LEN_W-1:0]   card_count;
	logic               card_bad;
	logic [DIGIT_W-1:0] card_sum_even;
	logic [DIGIT_W-1:0] card_sum_odd;
	logic [LEAD_W-1:0]  card_lead;

	bit idle_en;
	bit hold_go;
	int src_gap;
	int sink_gap;
	int hold_cnt;
	int quiet_cycles = 0;
	int fault_count = 0;
	int cards_checked = 0;
	int words_sent = 0;
	int words_queued = 0;
	int settings_used = 0;

	wire receiver_held = hold_go && (hold_cnt < HOLD_LEN);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic report_fault(input string msg);
		if (fault_count < PRINT_CAP) begin
			$display("ERROR: %s", msg);
		end
		fault_count++;
	endtask

	task automatic clear_card();
		card_count    = '0;
		card_bad      = 1'b0;
		card_sum_even = '0;
		card_sum_odd  = '0;
		card_lead     = '0;
	endtask

	task automatic absorb_word(input char_word_t w);
		int         d;
		int         dbl;
		int         nxt_odd;
		int         nxt_even;
		verdict_t   v;
		logic [3:0] first;
		logic [3:0] second;
		if (w.ch >= CHAR_ZERO && w.ch <= CHAR_NINE) begin
			d = int'(w.ch - CHAR_ZERO);
			dbl = 2 * d;
			if (dbl > 9) begin
				dbl -= 9;
			end
			nxt_odd  = (int'(card_sum_even) + d) % 10;
			nxt_even = (int'(card_sum_odd) + dbl) % 10;
			card_sum_odd  = 4'(nxt_odd);
			card_sum_even = 4'(nxt_even);
			if (card_count == 0) begin
				card_lead = {4'(d), 4'd0};
			end else if (card_count == 1) begin
				card_lead[3:0] = 4'(d);
			end
			if (card_count != COUNT_MAX) begin
				card_count++;
			end
		end else if (!((w.ch >= CHAR_TAB && w.ch <= CHAR_CR) || w.ch == CHAR_SPACE)) begin
			card_bad = 1'b1;
		end
		if (w.is_end) begin
			first  = card_lead[7:4];
			second = card_lead[3:0];
			if (card_bad) begin
				v.status = ST_NONDIGIT;
			end else if (card_count < len_min || card_count > len_max) begin
				v.status = ST_LENGTH;
			end else if (card_sum_odd != 0) begin
				v.status = ST_LUHN;
			end else begin
				v.status = ST_VALID;
			end
			if (card_count == 0) begin
				v.brand = BR_OTHER;
			end else if (card_count >= 2 && first == DIG_THREE &&
					(second == DIG_FOUR || second == DIG_SEVEN)) begin
				v.brand = BR_AMEX;
			end else if (first == DIG_THREE) begin
				v.brand = BR_JCB;
			end else if (first == DIG_FOUR) begin
				v.brand = BR_VISA;
			end else if (first == DIG_FIVE) begin
				v.brand = BR_MASTERCARD;
			end else if (first == DIG_SIX) begin
				v.brand = BR_MAESTRO;
			end else begin
				v.brand = BR_OTHER;
			end
			v.count = card_count;
			expected_verdicts.push_back(v);
			clear_card();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_if.valid     <= 1'b0;
			char_if.char_byte <= '0;
			char_if.is_last   <= 1'b0;
			src_gap           <= 0;
		end else begin
			if (char_if.valid && char_if.ready) begin
				absorb_word('{char_if.char_byte, char_if.is_last});
				words_sent++;
			end
			if (!char_if.valid || char_if.ready) begin
				if (src_gap > 0) begin
					char_if.valid <= 1'b0;
					src_gap       <= src_gap - 1;
				end else if (idle_en && $urandom_range(0, 5) == 0) begin
					char_if.valid <= 1'b0;
					src_gap       <= $urandom_range(0, 7);
				end else if (pending_words.size() > 0) begin
					next_word = pending_words.pop_front();
					char_if.valid     <= 1'b1;
					char_if.char_byte <= next_word.ch;
					char_if.is_last   <= next_word.is_end;
				end else begin
					char_if.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cnt <= 0;
		end else if (hold_go && hold_cnt < HOLD_LEN) begin
			hold_cnt <= hold_cnt + 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
			sink_gap     <= 0;
		end else if (receiver_held) begin
			res_if.ready <= 1'b0;
		end else if (sink_gap > 0) begin
			res_if.ready <= 1'b0;
			sink_gap     <= sink_gap - 1;
		end else if (idle_en && $urandom_range(0, 5) == 0) begin
			res_if.ready <= 1'b0;
			sink_gap     <= $urandom_range(0, 7);
		end else begin
			res_if.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready) begin
			if (expected_verdicts.size() == 0) begin
				report_fault($sformatf("unexpected result: status %0d brand %0d count %0d",
					res_if.status, res_if.brand, res_if.digit_count));
			end else begin
				want_verdict = expected_verdicts.pop_front();
				if (res_if.status !== want_verdict.status ||
						res_if.brand !== want_verdict.brand ||
						res_if.digit_count !== want_verdict.count) begin
					report_fault($sformatf(
						"number %0d: got status %0d brand %0d count %0d, want %0d %0d %0d",
						cards_checked, res_if.status, res_if.brand, res_if.digit_count,
						want_verdict.status, want_verdict.brand, want_verdict.count));
				end
				cards_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (char_if.valid && char_if.ready) || (res_if.valid && res_if.ready) ||
				(psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("card_number_validator_top test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic apb_write(input reg_index_t idx, input logic [DATA_W-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic check_register(input reg_index_t idx, input logic [LEN_W-1:0] want);
		logic [DATA_W-1:0] got;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		got = prdata;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got !== DATA_W'(want)) begin
			report_fault($sformatf("register %s reads %0h, want %0h", idx.name(), got, want));
		end
	endtask

	task automatic set_lengths(input logic [LEN_W-1:0] lo, input logic [LEN_W-1:0] hi);
		apb_write(REG_MIN_LENGTH, DATA_W'(lo));
		apb_write(REG_MAX_LENGTH, DATA_W'(hi));
		len_min = lo;
		len_max = hi;
		settings_used++;
		check_register(REG_MIN_LENGTH, lo);
		check_register(REG_MAX_LENGTH, hi);
	endtask

	task automatic queue_word(input logic [CHAR_W-1:0] ch, input logic is_end);
		pending_words.push_back('{ch, is_end});
		words_queued++;
	endtask

	function automatic logic [CHAR_W-1:0] pick_blank();
		return ($urandom_range(0, 5) == 5) ? CHAR_SPACE : CHAR_TAB + 8'($urandom_range(0, 4));
	endfunction

	function automatic logic [CHAR_W-1:0] pick_junk();
		logic [CHAR_W-1:0] c;
		do begin
			c = 8'($urandom_range(0, 255));
		end while ((c >= CHAR_ZERO && c <= CHAR_NINE) || (c >= CHAR_TAB && c <= CHAR_CR) ||
			c == CHAR_SPACE);
		return c;
	endfunction

	task automatic queue_card(input int n_digits, input bit luhn_good, input bit spoil);
		int digits[$];
		int sum;
		int t;
		int junk_at;
		for (int i = 0; i < n_digits; i++) begin
			digits.push_back($urandom_range(0, 9));
		end
		if (n_digits >= 2 && $urandom_range(0, 3) == 0) begin
			digits[0] = 3;
			digits[1] = $urandom_range(0, 1) ? 4 : 7;
		end else if (n_digits >= 1 && $urandom_range(0, 1) == 1) begin
			digits[0] = $urandom_range(3, 6);
		end
		if (luhn_good && n_digits > 0) begin
			sum = 0;
			for (int i = 0; i < n_digits - 1; i++) begin
				t = digits[n_digits - 2 - i];
				if (i % 2 == 0) begin
					t *= 2;
					if (t > 9) begin
						t -= 9;
					end
				end
				sum += t;
			end
			digits[n_digits - 1] = (10 - sum % 10) % 10;
		end
		junk_at = spoil ? $urandom_range(0, n_digits) : -1;
		for (int i = 0; i < n_digits; i++) begin
			if (i == junk_at) begin
				queue_word(pick_junk(), 1'b0);
			end
			if ($urandom_range(0, 5) == 0) begin
				queue_word(pick_blank(), 1'b0);
			end
			queue_word(CHAR_ZERO + 8'(digits[i]), 1'b0);
		end
		if (junk_at == n_digits) begin
			queue_word(pick_junk(), 1'b0);
		end
		if (pending_words.size() == 0 || n_digits == 0 || $urandom_range(0, 7) == 0) begin
			queue_word(pick_blank(), 1'b1);
		end else begin
			pending_words[$].is_end = 1'b1;
		end
	endtask

	task automatic queue_noise();
		int n;
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++) begin
			queue_word(8'($urandom), (i == n - 1) && ($urandom_range(0, 2) == 0));
		end
	endtask

	task automatic fill_phase(input int target, input int lo, input int hi);
		int goal;
		int n;
		goal = words_queued + target;
		while (words_queued < goal) begin
			if ($urandom_range(0, 9) < 7) begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(lo, hi);
				queue_card(n, $urandom_range(0, 9) < 7, $urandom_range(0, 9) == 0);
			end else begin
				queue_noise();
			end
		end
		if (pending_words.size() == 0 || !pending_words[$].is_end) begin
			queue_word(CHAR_SPACE, 1'b1);
		end
	endtask

	task automatic settle();
		do @(negedge clk);
		while (pending_words.size() != 0 || char_if.valid || expected_verdicts.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		arst_n            = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		char_if.valid     = 1'b0;
		char_if.char_byte = '0;
		char_if.is_last   = 1'b0;
		res_if.ready      = 1'b0;
		idle_en           = 1'b0;
		hold_go           = 1'b0;
		len_min           = MIN_LEN_RESET;
		len_max           = MAX_LEN_RESET;
		clear_card();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		check_register(REG_MIN_LENGTH, MIN_LEN_RESET);
		check_register(REG_MAX_LENGTH, MAX_LEN_RESET);
		settings_used = 1;

		queue_word(8'h00, 1'b0);
		queue_word(8'hFF, 1'b0);
		queue_word(CHAR_SPACE, 1'b1);
		queue_word(CHAR_TAB, 1'b1);
		queue_word(CHAR_ZERO + 8'd3, 1'b1);
		queue_word(CHAR_ZERO + 8'd3, 1'b0);
		queue_word(CHAR_ZERO + 8'd4, 1'b1);
		queue_word(CHAR_ZERO + 8'd3, 1'b0);
		queue_word(CHAR_ZERO + 8'd7, 1'b1);
		queue_word(CHAR_ZERO + 8'd4, 1'b0);
		queue_word(8'd10, 1'b0);
		queue_word(CHAR_ZERO + 8'd5, 1'b1);
		queue_word(CHAR_ZERO + 8'd5, 1'b1);
		queue_word(CHAR_ZERO + 8'd6, 1'b1);
		queue_word(CHAR_NINE, 1'b0);
		queue_word(8'd11, 1'b0);
		queue_word(8'd12, 1'b0);
		queue_word(CHAR_CR, 1'b0);
		queue_word(CHAR_ZERO, 1'b1);
		queue_word(CHAR_ZERO - 8'd1, 1'b0);
		queue_word(CHAR_NINE + 8'd1, 1'b0);
		queue_word(CHAR_TAB - 8'd1, 1'b0);
		queue_word(CHAR_CR + 8'd1, 1'b0);
		queue_word(CHAR_ZERO + 8'd7, 1'b1);
		settle();

		idle_en = 1'b1;
		set_lengths(5'd12, 5'd19);
		fill_phase(260, 12, 19);
		@(negedge clk);
		hold_go = 1'b1;
		settle();

		set_lengths(5'd1, 5'd31);
		fill_phase(200, 1, 31);
		settle();

		set_lengths(5'd31, 5'd1);
		fill_phase(100, 10, 20);
		settle();

		set_lengths(5'd0, 5'd5);
		fill_phase(100, 0, 7);
		settle();

		idle_en = 1'b0;
		set_lengths(5'd16, 5'd16);
		fill_phase(220, 14, 18);
		settle();

		if (expected_verdicts.size() != 0) begin
			report_fault($sformatf("%0d results never arrived", expected_verdicts.size()));
		end
		$display("Checked %0d card numbers from %0d characters under %0d length settings,",
			cards_checked, words_sent, settings_used);
		$display("with blanks, stray bytes, every brand, saturated counts and crossed bounds.");
		if (fault_count == 0) begin
			$display("card_number_validator_top test passed");
		end else begin
			$display("card_number_validator_top test failed");
		end
		$finish;
	end

endmodule
